// ===== rtl/crc_framed_packet_checker_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the CRC framed packet checker
// Shared property wrappers, clocked on clock, used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CRC_FRAMED_PACKET_CHECKER_TOP_MACROS_SVH
`define CRC_FRAMED_PACKET_CHECKER_TOP_MACROS_SVH

// Property that is checked only outside reset.
`define CFPC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cfpc assertion failed");

// Property that is also checked while reset is applied.
`define CFPC_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("cfpc assertion failed");

`endif

// ===== rtl/cfpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpc_pkg
// Types, constants and the byte-wide CRC-32 update for the frame checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfpc_pkg;

   localparam int unsigned HEADER_BYTES = 14;
   localparam int unsigned POS_WIDTH    = 4;

   localparam logic [POS_WIDTH-1:0] POS_FIRST       = POS_WIDTH'(0);
   localparam logic [POS_WIDTH-1:0] POS_VERSION     = POS_WIDTH'(4);
   localparam logic [POS_WIDTH-1:0] POS_FLAGS       = POS_WIDTH'(5);
   localparam logic [POS_WIDTH-1:0] POS_LEN_FIRST   = POS_WIDTH'(6);
   localparam logic [POS_WIDTH-1:0] POS_LEN_LAST    = POS_WIDTH'(9);
   localparam logic [POS_WIDTH-1:0] POS_CHECK_FIRST = POS_WIDTH'(10);
   localparam logic [POS_WIDTH-1:0] POS_END         = POS_WIDTH'(HEADER_BYTES);

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   localparam logic [31:0] MAGIC_WORD_RESET         = 32'd0;
   localparam logic [7:0]  EXPECTED_VERSION_RESET   = 8'd1;
   localparam logic [31:0] MAX_PAYLOAD_LENGTH_RESET = 32'd4096;

   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'd0,
      PHASE_PAYLOAD = 2'd1
   } phase_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_INCOMPLETE  = 3'd1,
      STATUS_BAD_MAGIC   = 3'd2,
      STATUS_BAD_VERSION = 3'd3,
      STATUS_TOO_LARGE   = 3'd4,
      STATUS_CRC_BAD     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CSR_MAGIC_WORD         = 2'd0,
      CSR_EXPECTED_VERSION   = 2'd1,
      CSR_MAX_PAYLOAD_LENGTH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [31:0] magic_word;
      logic [7:0]  expected_version;
      logic [31:0] max_payload_length;
   } cfg_type;

   typedef struct packed {
      logic        emit;
      logic        payload_valid;
      logic [7:0]  payload_data;
      logic        frame_done;
      status_type  frame_status;
      logic [7:0]  frame_version;
      logic [7:0]  frame_flags;
      logic [31:0] frame_payload_length;
   } result_type;

   // Reflected CRC-32 advanced by one byte, least significant bit first.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

// ===== rtl/cfpc_frame_parser.sv =====
// ----------------------------------------------------------------------------
// cfpc_frame_parser
// Header and payload parse state; computes the result of each accepted beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfpc_frame_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat_accept,
   input  logic [7:0]          stream_byte,
   input  logic                end_of_buffer,
   input  cfpc_pkg::cfg_type   cfg,
   output cfpc_pkg::result_type result
);

   cfpc_pkg::phase_type                 phase_ff, phase_in;
   logic [cfpc_pkg::POS_WIDTH-1:0]      pos_ff, pos_in;
   logic [7:0]                          version_ff, version_in;
   logic [7:0]                          flags_ff, flags_in;
   logic [31:0]                         length_ff, length_in;
   logic [31:0]                         check_ff, check_in;
   logic [31:0]                         crc_ff, crc_in;
   logic [31:0]                         remaining_ff, remaining_in;

   logic [cfpc_pkg::POS_WIDTH-1:0]      pos;
   logic [cfpc_pkg::POS_WIDTH-1:0]      pos_next;
   logic [31:0]                         crc_next;
   logic [31:0]                         remaining_dec;
   logic [7:0]                          magic_byte;
   logic [1:0]                          length_lane;
   logic [1:0]                          check_lane;
   logic                                done;
   logic                                pv;
   cfpc_pkg::status_type                status;

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      version_in    = version_ff;
      flags_in      = flags_ff;
      length_in     = length_ff;
      check_in      = check_ff;
      crc_in        = crc_ff;
      remaining_in  = remaining_ff;
      done          = 1'b0;
      pv            = 1'b0;
      status        = cfpc_pkg::STATUS_OK;
      crc_next      = cfpc_pkg::crc_byte(crc_ff, stream_byte);
      remaining_dec = remaining_ff - {31'd0, (remaining_ff != 32'd0)};
      pos           = (pos_ff >= cfpc_pkg::POS_END) ? cfpc_pkg::POS_FIRST : pos_ff;
      pos_next      = pos + cfpc_pkg::POS_WIDTH'(1);
      magic_byte    = 8'(cfg.magic_word >> {pos[1:0], 3'b000});
      length_lane   = 2'(pos - cfpc_pkg::POS_LEN_FIRST);
      check_lane    = 2'(pos - cfpc_pkg::POS_CHECK_FIRST);

      unique case (phase_ff)
         cfpc_pkg::PHASE_PAYLOAD: begin
            pv           = 1'b1;
            crc_in       = crc_next;
            remaining_in = remaining_dec;
            if (remaining_dec == 32'd0) begin
               done   = 1'b1;
               status = ((~crc_next) == check_ff) ? cfpc_pkg::STATUS_OK
                                                  : cfpc_pkg::STATUS_CRC_BAD;
            end
         end
         default: begin
            // A new header starts by clearing the fields held from the last one.
            if (pos == cfpc_pkg::POS_FIRST) begin
               version_in = 8'd0;
               flags_in   = 8'd0;
               length_in  = 32'd0;
               check_in   = 32'd0;
            end
            priority if (pos < cfpc_pkg::POS_VERSION) begin
               if (stream_byte != magic_byte) begin
                  done   = 1'b1;
                  status = cfpc_pkg::STATUS_BAD_MAGIC;
               end
            end else if (pos == cfpc_pkg::POS_VERSION) begin
               version_in = stream_byte;
               if (stream_byte != cfg.expected_version) begin
                  done   = 1'b1;
                  status = cfpc_pkg::STATUS_BAD_VERSION;
               end
            end else if (pos == cfpc_pkg::POS_FLAGS) begin
               flags_in = stream_byte;
            end else if (pos < cfpc_pkg::POS_CHECK_FIRST) begin
               length_in = length_in | ({24'd0, stream_byte} << {length_lane, 3'b000});
               if (pos == cfpc_pkg::POS_LEN_LAST && length_in > cfg.max_payload_length) begin
                  done   = 1'b1;
                  status = cfpc_pkg::STATUS_TOO_LARGE;
               end
            end else begin
               check_in = check_in | ({24'd0, stream_byte} << {check_lane, 3'b000});
            end

            if (!done) begin
               pos_in = pos_next;
               if (pos_next >= cfpc_pkg::POS_END) begin
                  pos_in = cfpc_pkg::POS_FIRST;
                  if (length_in == 32'd0) begin
                     // An empty payload has a CRC of zero.
                     done   = 1'b1;
                     status = (check_in == 32'd0) ? cfpc_pkg::STATUS_OK
                                                  : cfpc_pkg::STATUS_CRC_BAD;
                  end else begin
                     phase_in     = cfpc_pkg::PHASE_PAYLOAD;
                     remaining_in = length_in;
                     crc_in       = cfpc_pkg::CRC_ONES;
                  end
               end
            end
         end
      endcase

      if (!done && end_of_buffer) begin
         done   = 1'b1;
         status = cfpc_pkg::STATUS_INCOMPLETE;
      end
      if (done) begin
         phase_in     = cfpc_pkg::PHASE_HEADER;
         pos_in       = cfpc_pkg::POS_FIRST;
         remaining_in = 32'd0;
      end

      result.emit                 = pv | done;
      result.payload_valid        = pv;
      result.payload_data         = pv ? stream_byte : 8'd0;
      result.frame_done           = done;
      result.frame_status         = done ? status : cfpc_pkg::STATUS_OK;
      result.frame_version        = version_in;
      result.frame_flags          = flags_in;
      result.frame_payload_length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cfpc_pkg::PHASE_HEADER;
         pos_ff       <= cfpc_pkg::POS_FIRST;
         version_ff   <= 8'd0;
         flags_ff     <= 8'd0;
         length_ff    <= 32'd0;
         check_ff     <= 32'd0;
         crc_ff       <= cfpc_pkg::CRC_ONES;
         remaining_ff <= 32'd0;
      end else if (beat_accept) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         version_ff   <= version_in;
         flags_ff     <= flags_in;
         length_ff    <= length_in;
         check_ff     <= check_in;
         crc_ff       <= crc_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

// ===== rtl/crc_framed_packet_checker_top.sv =====
// ----------------------------------------------------------------------------
// crc_framed_packet_checker_top
// Length-prefixed frame deframer with header checks and payload CRC-32.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one stream byte per beat, with end_of_buffer set
// on the last byte available. Each frame is a 14-byte header (four magic
// bytes, version, flags, little-endian length, little-endian CRC-32) and a
// payload. Header beats produce no rsp beat unless they end the frame (on
// an error or an empty payload) or meet end of buffer. Every payload byte
// produces one rsp beat carrying that byte; the last one also carries
// frame_done and the status. A result appears on rsp in the cycle after
// its req beat is accepted. Bytes are taken one per cycle unless rsp
// stalls; the CRC for one byte is eight unrolled xor steps between the
// parse state and the rsp register. The rsp register is a single stage:
// req_ready stays high while it is empty or being drained, so a stalled
// receiver holds the result in place and back-pressures req only for as
// long as rsp_ready stays low. Reset empties the rsp register, returns
// the parser to hunting for a header and restores the configuration
// registers to their reset values. The csr port writes one register per
// cycle and must be used only while no frame is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_framed_packet_checker_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_end_of_buffer,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_payload_valid,
   output logic [7:0]  rsp_payload_data,
   output logic        rsp_frame_done,
   output logic [2:0]  rsp_frame_status,
   output logic [7:0]  rsp_frame_version,
   output logic [7:0]  rsp_frame_flags,
   output logic [31:0] rsp_frame_payload_length,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   cfpc_pkg::cfg_type    cfg_ff;
   cfpc_pkg::result_type result;
   cfpc_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 beat_accept;

   // Configuration registers; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_word         <= cfpc_pkg::MAGIC_WORD_RESET;
         cfg_ff.expected_version   <= cfpc_pkg::EXPECTED_VERSION_RESET;
         cfg_ff.max_payload_length <= cfpc_pkg::MAX_PAYLOAD_LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            cfpc_pkg::CSR_MAGIC_WORD:         cfg_ff.magic_word <= csr_write_data;
            cfpc_pkg::CSR_EXPECTED_VERSION:   cfg_ff.expected_version <= csr_write_data[7:0];
            cfpc_pkg::CSR_MAX_PAYLOAD_LENGTH: cfg_ff.max_payload_length <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // A new byte is taken whenever the rsp register is free at the next edge.
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign beat_accept = req_valid && req_ready;

   cfpc_frame_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .beat_accept   (beat_accept),
      .stream_byte   (req_stream_byte),
      .end_of_buffer (req_end_of_buffer),
      .cfg           (cfg_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (beat_accept) begin
         rsp_valid_ff <= result.emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload holds while a beat waits; it has no reset.
   always_ff @(posedge clock) begin
      if (beat_accept && result.emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_payload_valid        = rsp_ff.payload_valid;
   assign rsp_payload_data         = rsp_ff.payload_data;
   assign rsp_frame_done           = rsp_ff.frame_done;
   assign rsp_frame_status         = rsp_ff.frame_status;
   assign rsp_frame_version        = rsp_ff.frame_version;
   assign rsp_frame_flags          = rsp_ff.frame_flags;
   assign rsp_frame_payload_length = rsp_ff.frame_payload_length;

endmodule

// ===== rtl/cfpc_checker.sv =====
// ----------------------------------------------------------------------------
// cfpc_checker
// Port-level checks of the frame checker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "crc_framed_packet_checker_top_macros.svh"

module cfpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_payload_valid,
   input logic [7:0]  rsp_payload_data,
   input logic        rsp_frame_done,
   input logic [2:0]  rsp_frame_status,
   input logic [7:0]  rsp_frame_version,
   input logic [7:0]  rsp_frame_flags,
   input logic [31:0] rsp_frame_payload_length
);

   logic [60:0] rsp_fields;
   logic        status_clear;
   logic        data_clear;

   // All result fields side by side, so that one stability check covers them.
   assign rsp_fields   = {rsp_payload_valid, rsp_payload_data, rsp_frame_done, rsp_frame_status,
                          rsp_frame_version, rsp_frame_flags, rsp_frame_payload_length};
   assign status_clear = rsp_frame_done || (rsp_frame_status == cfpc_pkg::STATUS_OK);
   assign data_clear   = rsp_payload_valid || (rsp_payload_data == 8'd0);

   // A stalled result beat stays offered and unchanged.
   `CFPC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fields))

   // Every result beat carries a payload byte, a frame end, or both.
   `CFPC_ASSERT(a_rsp_content, rsp_valid |-> rsp_payload_valid || rsp_frame_done)

   // Status and payload data are zero where they carry no meaning.
   `CFPC_ASSERT(a_rsp_zero_fields, rsp_valid |-> status_clear && data_clear)

   // The single result stage frees the input side whenever it is empty or drains.
   `CFPC_ASSERT(a_req_ready, !rsp_valid || rsp_ready |-> req_ready)

   // Reset leaves no result beat on offer.
   `CFPC_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid)

endmodule

bind crc_framed_packet_checker_top cfpc_checker u_cfpc_checker (
   .clock                    (clock),
   .reset                    (reset),
   .req_ready                (req_ready),
   .rsp_valid                (rsp_valid),
   .rsp_ready                (rsp_ready),
   .rsp_payload_valid        (rsp_payload_valid),
   .rsp_payload_data         (rsp_payload_data),
   .rsp_frame_done           (rsp_frame_done),
   .rsp_frame_status         (rsp_frame_status),
   .rsp_frame_version        (rsp_frame_version),
   .rsp_frame_flags          (rsp_frame_flags),
   .rsp_frame_payload_length (rsp_frame_payload_length)
);

// ===== tb/crc_frame_result_checker.sv =====
// ----------------------------------------------------------------------------
// crc_frame_result_checker
// Watches the req, rsp and csr ports of the frame checker, keeps its own
// copy of the deframer state and compares every rsp beat with the beat that
// the accepted stream bytes call for.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfpc_tb_pkg;

   import cfpc_pkg::*;

   // Reflected CRC-32, one data bit at a time, least significant bit first.
   function automatic logic [31:0] crc32_next(input logic [31:0] acc, input logic [7:0] data);
      logic [31:0] r;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         if (r[0] ^ data[i]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

endpackage

module crc_frame_result_checker
   import cfpc_pkg::*;
   import cfpc_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_end_of_buffer,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_payload_valid,
   input  logic [7:0]  rsp_payload_data,
   input  logic        rsp_frame_done,
   input  logic [2:0]  rsp_frame_status,
   input  logic [7:0]  rsp_frame_version,
   input  logic [7:0]  rsp_frame_flags,
   input  logic [31:0] rsp_frame_payload_length,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,

   output int          failures,
   output int          outstanding,
   output int          beats_checked,
   output int          verdicts_checked
);

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_data;
      logic        frame_done;
      logic [2:0]  frame_status;
      logic [7:0]  frame_version;
      logic [7:0]  frame_flags;
      logic [31:0] frame_payload_length;
   } frame_beat_t;

   // Register copies.
   logic [31:0] want_magic;
   logic [7:0]  want_version;
   logic [31:0] size_limit;

   // Deframer state.
   phase_type   rx_phase;
   logic [3:0]  hdr_pos;
   logic [7:0]  hdr_version;
   logic [7:0]  hdr_flags;
   logic [31:0] hdr_length;
   logic [31:0] hdr_crc;
   logic [31:0] payload_crc;
   logic [31:0] bytes_left;

   frame_beat_t predicted_beats[$];
   frame_beat_t observed;
   frame_beat_t wanted;
   int          fail_tally;
   int          seen_tally;
   int          done_tally;

   // Advances the deframer by one stream byte and queues the rsp beat it causes.
   task automatic predict_byte(input logic [7:0] b, input logic eob);
      frame_beat_t beat;
      logic        pv;
      logic        done;
      status_type  st;
      logic [3:0]  p;
      pv   = 1'b0;
      done = 1'b0;
      st   = STATUS_OK;
      if (rx_phase == PHASE_PAYLOAD) begin
         pv = 1'b1;
         payload_crc = crc32_next(payload_crc, b);
         if (bytes_left != 0) begin
            bytes_left = bytes_left - 1;
         end
         if (bytes_left == 0) begin
            done = 1'b1;
            st = ((~payload_crc) == hdr_crc) ? STATUS_OK : STATUS_CRC_BAD;
         end
      end else begin
         if (hdr_pos >= POS_END) begin
            hdr_pos = POS_FIRST;
         end
         p = hdr_pos;
         if (p == POS_FIRST) begin
            hdr_version = '0;
            hdr_flags   = '0;
            hdr_length  = '0;
            hdr_crc     = '0;
         end
         if (p < POS_VERSION) begin
            if (b != want_magic[8*p +: 8]) begin
               done = 1'b1;
               st = STATUS_BAD_MAGIC;
            end
         end else if (p == POS_VERSION) begin
            hdr_version = b;
            if (b != want_version) begin
               done = 1'b1;
               st = STATUS_BAD_VERSION;
            end
         end else if (p == POS_FLAGS) begin
            hdr_flags = b;
         end else if (p <= POS_LEN_LAST) begin
            hdr_length = hdr_length | ({24'd0, b} << (8 * (p - POS_LEN_FIRST)));
            if (p == POS_LEN_LAST && hdr_length > size_limit) begin
               done = 1'b1;
               st = STATUS_TOO_LARGE;
            end
         end else begin
            hdr_crc = hdr_crc | ({24'd0, b} << (8 * (p - POS_CHECK_FIRST)));
         end
         if (!done) begin
            hdr_pos = p + 1'b1;
            if (hdr_pos >= POS_END) begin
               hdr_pos = POS_FIRST;
               if (hdr_length == 0) begin
                  // An empty payload must carry the CRC of nothing, which is zero.
                  done = 1'b1;
                  st = (hdr_crc == 0) ? STATUS_OK : STATUS_CRC_BAD;
               end else begin
                  rx_phase    = PHASE_PAYLOAD;
                  bytes_left  = hdr_length;
                  payload_crc = CRC_ONES;
               end
            end
         end
      end
      if (!done && eob) begin
         done = 1'b1;
         st = STATUS_INCOMPLETE;
      end
      if (done) begin
         rx_phase   = PHASE_HEADER;
         hdr_pos    = POS_FIRST;
         bytes_left = '0;
      end
      if (pv || done) begin
         beat.payload_valid        = pv;
         beat.payload_data         = pv ? b : 8'd0;
         beat.frame_done           = done;
         beat.frame_status         = done ? st : STATUS_OK;
         beat.frame_version        = hdr_version;
         beat.frame_flags          = hdr_flags;
         beat.frame_payload_length = hdr_length;
         predicted_beats.push_back(beat);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         want_magic   = MAGIC_WORD_RESET;
         want_version = EXPECTED_VERSION_RESET;
         size_limit   = MAX_PAYLOAD_LENGTH_RESET;
         rx_phase     = PHASE_HEADER;
         hdr_pos      = POS_FIRST;
         hdr_version  = '0;
         hdr_flags    = '0;
         hdr_length   = '0;
         hdr_crc      = '0;
         payload_crc  = CRC_ONES;
         bytes_left   = '0;
         predicted_beats.delete();
         fail_tally   = 0;
         seen_tally   = 0;
         done_tally   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            observed = {rsp_payload_valid, rsp_payload_data, rsp_frame_done, rsp_frame_status,
                        rsp_frame_version, rsp_frame_flags, rsp_frame_payload_length};
            seen_tally++;
            if (rsp_frame_done) begin
               done_tally++;
            end
            if (predicted_beats.size() == 0) begin
               if (fail_tally < 10) begin
                  $display("%0t: rsp beat with nothing predicted: pv=%0b data=%02h done=%0b",
                           $time, observed.payload_valid, observed.payload_data,
                           observed.frame_done);
               end
               fail_tally++;
            end else begin
               wanted = predicted_beats.pop_front();
               if (observed.payload_valid !== wanted.payload_valid ||
                   observed.payload_data !== wanted.payload_data ||
                   observed.frame_done !== wanted.frame_done ||
                   observed.frame_status !== wanted.frame_status ||
                   observed.frame_version !== wanted.frame_version ||
                   observed.frame_flags !== wanted.frame_flags ||
                   observed.frame_payload_length !== wanted.frame_payload_length) begin
                  if (fail_tally < 10) begin
                     $display("%0t: rsp mismatch expected pv=%0b data=%02h done=%0b st=%0d",
                              $time, wanted.payload_valid, wanted.payload_data,
                              wanted.frame_done, wanted.frame_status);
                     $display("   ver=%02h flags=%02h len=%08h", wanted.frame_version,
                              wanted.frame_flags, wanted.frame_payload_length);
                     $display("   actual pv=%0b data=%02h done=%0b st=%0d",
                              observed.payload_valid, observed.payload_data,
                              observed.frame_done, observed.frame_status);
                     $display("   ver=%02h flags=%02h len=%08h", observed.frame_version,
                              observed.frame_flags, observed.frame_payload_length);
                  end
                  fail_tally++;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_MAGIC_WORD: begin
                  want_magic = csr_write_data;
               end
               CSR_EXPECTED_VERSION: begin
                  want_version = csr_write_data[7:0];
               end
               CSR_MAX_PAYLOAD_LENGTH: begin
                  size_limit = csr_write_data;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            predict_byte(req_stream_byte, req_end_of_buffer);
         end
      end
      failures         <= fail_tally;
      outstanding      <= predicted_beats.size();
      beats_checked    <= seen_tally;
      verdicts_checked <= done_tally;
   end

endmodule

// ===== tb/crc_framed_packet_checker_top_test.sv =====
// ----------------------------------------------------------------------------
// crc_framed_packet_checker_top_test
// Feeds the frame checker a byte stream of well-formed frames, damaged
// frames, cut-off frames and noise under several register settings, with
// random idle cycles on both channels, and lets the result checker compare
// every rsp beat against its own deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_framed_packet_checker_top_test;

   import cfpc_pkg::*;
   import cfpc_tb_pkg::*;

   // Roughly how many random stream bytes go out under each register setting.
   localparam int BYTES_PER_SETTING = 160;
   localparam int NUM_SETTINGS      = 5;
   // The result register is one stage deep, so this settling wait after the last
   // predicted beat arrives leaves the block certainly quiet.
   localparam int SETTLE_CYCLES     = 4;
   // The one long receiver hold-off.
   localparam int RSP_HOLD_CYCLES   = 150;
   // The longest quiet stretch in a correct run is the receiver hold-off plus
   // the tail of a random idle run. The watchdog allows a quiet stretch of up
   // to QUIET_LIMIT before calling the run hung.
   localparam int QUIET_LIMIT       = 2000;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_MAGIC,
      FRAME_BAD_VERSION,
      FRAME_TOO_LARGE,
      FRAME_BAD_CRC,
      FRAME_TRUNCATED,
      FRAME_NOISE
   } frame_kind_t;

   logic        clock;
   logic        reset             = 1'b1;

   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte   = 8'd0;
   logic        req_end_of_buffer = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic        rsp_payload_valid;
   logic [7:0]  rsp_payload_data;
   logic        rsp_frame_done;
   logic [2:0]  rsp_frame_status;
   logic [7:0]  rsp_frame_version;
   logic [7:0]  rsp_frame_flags;
   logic [31:0] rsp_frame_payload_length;

   logic        csr_write_enable  = 1'b0;
   logic [1:0]  csr_index         = 2'd0;
   logic [31:0] csr_write_data    = 32'd0;

   // Shared between the stimulus and the receiver: random idling on or off,
   // and the request for the single long receiver hold-off.
   logic        idle_mode         = 1'b0;
   logic        long_hold_req     = 1'b0;

   int          mismatches;
   int          pending;
   int          beats_seen;
   int          verdicts_seen;

   // What the stimulus last programmed, so that frames can be built to pass
   // or fail the header checks on purpose.
   logic [31:0] cur_magic         = MAGIC_WORD_RESET;
   logic [7:0]  cur_version       = EXPECTED_VERSION_RESET;
   logic [31:0] cur_max           = MAX_PAYLOAD_LENGTH_RESET;

   int          bytes_sent        = 0;
   int          frames_sent       = 0;

   crc_framed_packet_checker_top dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_stream_byte          (req_stream_byte),
      .req_end_of_buffer        (req_end_of_buffer),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_payload_valid        (rsp_payload_valid),
      .rsp_payload_data         (rsp_payload_data),
      .rsp_frame_done           (rsp_frame_done),
      .rsp_frame_status         (rsp_frame_status),
      .rsp_frame_version        (rsp_frame_version),
      .rsp_frame_flags          (rsp_frame_flags),
      .rsp_frame_payload_length (rsp_frame_payload_length),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data)
   );

   crc_frame_result_checker result_check (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_stream_byte          (req_stream_byte),
      .req_end_of_buffer        (req_end_of_buffer),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_payload_valid        (rsp_payload_valid),
      .rsp_payload_data         (rsp_payload_data),
      .rsp_frame_done           (rsp_frame_done),
      .rsp_frame_status         (rsp_frame_status),
      .rsp_frame_version        (rsp_frame_version),
      .rsp_frame_flags          (rsp_frame_flags),
      .rsp_frame_payload_length (rsp_frame_payload_length),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data),
      .failures                 (mismatches),
      .outstanding              (pending),
      .beats_checked            (beats_seen),
      .verdicts_checked         (verdicts_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver. With idling on, rsp_ready drops at random with a 31 percent
   // chance. Once, on request, it holds rsp_ready low for a long stretch so
   // that the single result stage fills and req_ready goes low behind it.
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= !(idle_mode && ($urandom_range(0, 99) < 31));
      end
   end

   // Watchdog: ends the run when nothing has moved on either channel for too
   // long. A correct run never gets near the limit.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("crc_framed_packet_checker_top_test: errors");
      $finish;
   end

   // Offers one stream byte and holds it until it is accepted. The idle run,
   // if any, follows the accepted beat, so valid only drops when a gap really
   // comes and is never lowered and raised within one step.
   task automatic send_beat(input logic [7:0] b, input logic eob);
      req_valid         <= 1'b1;
      req_stream_byte   <= b;
      req_end_of_buffer <= eob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      if (idle_mode && ($urandom_range(0, 99) < 31)) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 31);
      end
   endtask

   // Stops offering and waits until every predicted rsp beat has been taken,
   // plus a settling wait for the result stage to empty. The count is first read
   // once the clock has advanced, so that it already includes the last accepted byte.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers on consecutive cycles; the enable stays high
   // across the three writes.
   task automatic program_regs(input logic [31:0] magic, input logic [7:0] version,
                               input logic [31:0] limit);
      cur_magic   = magic;
      cur_version = version;
      cur_max     = limit;
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MAGIC_WORD;
      csr_write_data   <= magic;
      @(posedge clock);
      csr_index        <= CSR_EXPECTED_VERSION;
      csr_write_data   <= {24'd0, version};
      @(posedge clock);
      csr_index        <= CSR_MAX_PAYLOAD_LENGTH;
      csr_write_data   <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Well-formed frames are the largest share, so that the payload phase and
   // the CRC are exercised deeply; the rest is damaged frames and noise.
   function automatic frame_kind_t pick_kind();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return FRAME_GOOD;
      end else if (r < 55) begin
         return FRAME_BAD_CRC;
      end else if (r < 67) begin
         return FRAME_TRUNCATED;
      end else if (r < 75) begin
         return FRAME_BAD_MAGIC;
      end else if (r < 83) begin
         return FRAME_BAD_VERSION;
      end else if (r < 90) begin
         return FRAME_TOO_LARGE;
      end
      return FRAME_NOISE;
   endfunction

   // Builds one frame for the current register setting, damages it as the
   // kind asks, and sends it. Header errors end the frame in the block, so
   // such frames are sent only up to the offending byte.
   task automatic send_frame(input frame_kind_t kind);
      logic [7:0]  frame_bytes[$];
      logic [7:0]  body[$];
      logic [31:0] len;
      logic [31:0] crc;
      logic [31:0] flip;
      frame_kind_t k;
      int unsigned cap;
      int unsigned n;
      int unsigned keep;
      int unsigned eob_at;
      int unsigned p;
      k = kind;
      if (k == FRAME_NOISE) begin
         n = $urandom_range(1, 6);
         repeat (n) send_beat(8'($urandom), ($urandom_range(0, 9) == 0));
         return;
      end
      // With no room above the limit, a size error cannot be made.
      if (k == FRAME_TOO_LARGE && cur_max == 32'hFFFF_FFFF) begin
         k = FRAME_BAD_CRC;
      end
      // Payloads are mostly short, now and then up to two hundred bytes.
      cap = (cur_max < 24) ? cur_max : 24;
      if ($urandom_range(0, 15) == 0) begin
         cap = (cur_max < 200) ? cur_max : 200;
      end
      len = $urandom_range(0, cap);
      if (k == FRAME_TOO_LARGE) begin
         len = cur_max + 1 + ($urandom % (32'hFFFF_FFFF - cur_max));
      end else if (k == FRAME_TRUNCATED && cur_max > 24 && $urandom_range(0, 1) == 1) begin
         // A cut-off frame may claim a huge length; above 200, only 24 payload bytes are built.
         len = $urandom_range(25, cur_max);
      end
      n = (len <= 200) ? len : 24;
      crc = CRC_ONES;
      repeat (n) begin
         body.push_back(8'($urandom));
         crc = crc32_next(crc, body[body.size() - 1]);
      end
      crc = ~crc;
      if (k == FRAME_BAD_CRC) begin
         flip = $urandom;
         if (flip == 0) begin
            flip = 32'd1;
         end
         crc = crc ^ flip;
      end
      for (int i = 0; i < 4; i++) begin
         frame_bytes.push_back(cur_magic[8*i +: 8]);
      end
      frame_bytes.push_back(cur_version);
      frame_bytes.push_back(8'($urandom));
      for (int i = 0; i < 4; i++) begin
         frame_bytes.push_back(len[8*i +: 8]);
      end
      for (int i = 0; i < 4; i++) begin
         frame_bytes.push_back(crc[8*i +: 8]);
      end
      foreach (body[i]) begin
         frame_bytes.push_back(body[i]);
      end
      keep = frame_bytes.size();
      case (k)
         FRAME_BAD_MAGIC: begin
            p = $urandom_range(0, 3);
            frame_bytes[p] = frame_bytes[p] ^ 8'($urandom_range(1, 255));
            keep = p + 1;
         end
         FRAME_BAD_VERSION: begin
            frame_bytes[POS_VERSION] = frame_bytes[POS_VERSION] ^ 8'($urandom_range(1, 255));
            keep = POS_VERSION + 1;
         end
         FRAME_TOO_LARGE: begin
            keep = POS_LEN_LAST + 1;
         end
         default: begin
         end
      endcase
      // A cut-off frame ends with end of buffer anywhere; other frames carry
      // it now and then on their last byte, where the frame's own ending wins.
      eob_at = keep;
      if (k == FRAME_TRUNCATED) begin
         eob_at = $urandom_range(0, keep - 1);
         keep = eob_at + 1;
      end else if ($urandom_range(0, 3) == 0) begin
         eob_at = keep - 1;
      end
      for (int unsigned i = 0; i < keep; i++) begin
         send_beat(frame_bytes[i], (i == eob_at));
      end
      frames_sent++;
   endtask

   initial begin
      int  phase_end;
      int  phase_mid;
      int  base;
      bit  hold_armed;
      bit  paused;
      hold_armed = 1'b0;
      paused = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening under the reset setting: magic of all zeros,
      // version one, size limit 4096.
      idle_mode <= 1'b1;
      // A first byte that is not magic.
      send_beat(8'hFF, 1'b0);
      // End of buffer on a first header byte that does match.
      send_beat(8'h00, 1'b1);
      // Correct magic, then a wrong version byte.
      repeat (4) send_beat(8'h00, 1'b0);
      send_beat(8'hFE, 1'b0);
      // An empty frame with a zero CRC, ended together with end of buffer.
      repeat (4) send_beat(8'h00, 1'b0);
      send_beat(EXPECTED_VERSION_RESET, 1'b0);
      send_beat(8'hA5, 1'b0);
      repeat (7) send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b1);
      base = bytes_sent;

      for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
         if (phase != 0) begin
            // The previous phase ended on end of buffer, so the parser is
            // hunting for a header; once the last result is out it is idle.
            drain_results();
            case (phase)
               1: program_regs(32'hFFFF_FFFF, 8'd0, 32'd0);
               2: program_regs($urandom, 8'hFF, 32'hFFFF_FFFF);
               3: program_regs($urandom, 8'($urandom), $urandom_range(1, 40));
               default: program_regs($urandom, 8'($urandom), MAX_PAYLOAD_LENGTH_RESET);
            endcase
            // The second setting runs without any idling on either side.
            idle_mode <= (phase != 1);
         end
         phase_end = base + (phase + 1) * BYTES_PER_SETTING;
         phase_mid = phase_end - BYTES_PER_SETTING / 2;
         while (bytes_sent < phase_end) begin
            if (phase == 2 && !hold_armed && bytes_sent >= phase_mid) begin
               // The sender keeps offering while the receiver holds off.
               long_hold_req <= 1'b1;
               hold_armed = 1'b1;
            end
            if (phase == 3 && !paused && bytes_sent >= phase_mid) begin
               // The sender goes quiet, possibly mid-frame, until all
               // results so far have come out.
               drain_results();
               paused = 1'b1;
            end
            send_frame(pick_kind());
         end
         send_beat(8'($urandom), 1'b1);
      end

      drain_results();
      $display("sent %0d stream bytes, %0d built frames plus noise, under %0d settings",
               bytes_sent, frames_sent, NUM_SETTINGS);
      $display("checked %0d rsp beats, %0d of them frame verdicts", beats_seen, verdicts_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("crc_framed_packet_checker_top_test: clean");
      end else begin
         $display("crc_framed_packet_checker_top_test: errors");
      end
      $finish;
   end

endmodule
